[sv/rbm_pkg.sv]
package rbm_pkg;

    localparam int CHR_SLOTS      = 8;
    localparam int CHR_IDX_W      = $clog2(CHR_SLOTS);
    localparam int PRG_COUNT_W    = 9;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = PRG_COUNT_W;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 48;

    localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RESET = 9'd32;

    // address bits 15..12 of a cpu write
    localparam logic [3:0] PAGE_PRG_LO     = 4'h8;
    localparam logic [3:0] PAGE_MIRROR_PRG = 4'h9;
    localparam logic [3:0] PAGE_CHR_0      = 4'hB;
    localparam logic [3:0] PAGE_CHR_1      = 4'hC;
    localparam logic [3:0] PAGE_CHR_2      = 4'hD;
    localparam logic [3:0] PAGE_CHR_3      = 4'hE;
    localparam logic [3:0] PAGE_IRQ        = 4'hF;

    typedef enum logic [1:0] {
        IRQ_SUB_RELOAD  = 2'd0,
        IRQ_SUB_CONTROL = 2'd1,
        IRQ_SUB_ACK     = 2'd2,
        IRQ_SUB_NONE    = 2'd3
    } irq_sub_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRG_COUNT   = 2'd0,
        CFG_CHR_IS_RAM  = 2'd1,
        CFG_QUAD_SCREEN = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_TICK  = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [15:0]            address;
        logic [7:0]             data;
        logic                   rendering_on;
    } item_t;

    typedef struct packed {
        logic [PRG_COUNT_W-1:0] prg_bank_count;
        logic                   chr_is_ram;
        logic                   quad_screen;
    } cfg_t;

    // first member is the most significant, so prg_bank_0 sits in the low bits
    typedef struct packed {
        logic                 irq_ack;
        logic                 irq_raise;
        logic [7:0]           chr_bank;
        logic [CHR_IDX_W-1:0] chr_slot;
        logic                 chr_update;
        logic                 mirror_apply;
        logic [1:0]           mirror_mode;
        logic [7:0]           prg_bank_3;
        logic [7:0]           prg_bank_2;
        logic [4:0]           prg_bank_1;
        logic [4:0]           prg_bank_0;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

[sv/rbm_core.sv]
module rbm_core
    import rbm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    commit,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [4:0]           prg_select_lo_reg, prg_select_lo_next;
    logic [4:0]           prg_select_hi_reg, prg_select_hi_next;
    logic [7:0]           chr_banks_reg [CHR_SLOTS];
    logic [1:0]           mirror_reg, mirror_next;
    logic                 irq_enabled_reg, irq_enabled_next;
    logic [7:0]           irq_reload_reg, irq_reload_next;
    logic [7:0]           irq_count_reg, irq_count_next;

    logic [3:0]           page;
    logic [3:0]           chr_page_off;
    logic [CHR_IDX_W-1:0] chr_idx;
    logic [7:0]           chr_old;
    logic [7:0]           chr_new;
    logic                 chr_we;
    irq_sub_t             irq_sub;
    logic [PRG_COUNT_W-1:0] fixed_2;
    logic [PRG_COUNT_W-1:0] fixed_3;

    assign page         = item.address[15:12];
    assign chr_page_off = page - PAGE_CHR_0;
    assign chr_idx      = {chr_page_off[1:0], item.address[0]};
    assign chr_old      = chr_banks_reg[chr_idx];
    assign chr_new      = item.address[1] ? {item.data[3:0], chr_old[3:0]}
                                          : {chr_old[7:4], item.data[3:0]};
    assign irq_sub      = irq_sub_t'(item.address[1:0]);
    assign fixed_2      = cfg.prg_bank_count - PRG_COUNT_W'(2);
    assign fixed_3      = cfg.prg_bank_count - PRG_COUNT_W'(1);

    always_comb begin
        prg_select_lo_next = prg_select_lo_reg;
        prg_select_hi_next = prg_select_hi_reg;
        mirror_next        = mirror_reg;
        irq_enabled_next   = irq_enabled_reg;
        irq_reload_next    = irq_reload_reg;
        irq_count_next     = irq_count_reg;
        chr_we             = 1'b0;
        result             = '0;

        if (item.action == ACTION_TICK) begin
            if (irq_enabled_reg && item.rendering_on) begin
                if (irq_count_reg == 8'd0) begin
                    irq_count_next   = irq_reload_reg;
                    result.irq_raise = 1'b1;
                end else begin
                    irq_count_next = irq_count_reg - 8'd1;
                end
            end
        end else if (item.address[15]) begin
            unique case (page)
                PAGE_PRG_LO: begin
                    prg_select_lo_next = item.data[4:0];
                end
                PAGE_MIRROR_PRG: begin
                    if (item.address[0]) begin
                        mirror_next         = item.data[1:0];
                        result.mirror_apply = !cfg.quad_screen;
                    end else begin
                        prg_select_hi_next = item.data[4:0];
                    end
                end
                PAGE_CHR_0, PAGE_CHR_1, PAGE_CHR_2, PAGE_CHR_3: begin
                    if (!cfg.chr_is_ram) begin
                        chr_we            = 1'b1;
                        result.chr_update = 1'b1;
                        result.chr_slot   = chr_idx;
                        result.chr_bank   = chr_new;
                    end
                end
                PAGE_IRQ: begin
                    unique case (irq_sub)
                        IRQ_SUB_RELOAD: irq_reload_next = item.data;
                        IRQ_SUB_CONTROL: begin
                            irq_enabled_next = item.data[1];
                            if (item.data[1]) begin
                                irq_count_next = irq_reload_reg;
                            end
                        end
                        IRQ_SUB_ACK: begin
                            irq_enabled_next = 1'b0;
                            result.irq_ack   = 1'b1;
                        end
                        IRQ_SUB_NONE: ;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        result.prg_bank_0  = prg_select_lo_next;
        result.prg_bank_1  = prg_select_hi_next;
        result.prg_bank_2  = fixed_2[7:0];
        result.prg_bank_3  = fixed_3[7:0];
        result.mirror_mode = mirror_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_select_lo_reg <= '0;
            prg_select_hi_reg <= '0;
            mirror_reg        <= '0;
            irq_enabled_reg   <= 1'b0;
            irq_reload_reg    <= '0;
            irq_count_reg     <= '0;
            for (int i = 0; i < CHR_SLOTS; i++) begin
                chr_banks_reg[i] <= '0;
            end
        end else if (commit) begin
            prg_select_lo_reg <= prg_select_lo_next;
            prg_select_hi_reg <= prg_select_hi_next;
            mirror_reg        <= mirror_next;
            irq_enabled_reg   <= irq_enabled_next;
            irq_reload_reg    <= irq_reload_next;
            irq_count_reg     <= irq_count_next;
            if (chr_we) begin
                chr_banks_reg[chr_idx] <= chr_new;
            end
        end
    end

endmodule

[sv/rom_bank_mapper_scanline_irq.sv]
// path: an accepted request passes the input register, then the result register, before its result is on m_tdata
// throughput: one request per cycle, sustained while m_tready is high, whatever the mix of writes and ticks
// the rate is set by the combinational state update between the input and result registers
// reset: aresetn is synchronous, active low; it empties both registers, clears all bank,
// mirroring and irq state and loads the defaults of the configuration registers;
// s_tready stays low while aresetn is low
module rom_bank_mapper_scanline_irq
    import rbm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // address[15:0], data[23:16], rendering_on[24]
    input  logic                   s_tuser,   // action: 0 cpu write, 1 scanline tick

    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // prg_bank_0[4:0], prg_bank_1[9:5], prg_bank_2[17:10], prg_bank_3[25:18],
    // mirror_mode[27:26], mirror_apply[28], chr_update[29], chr_slot[32:30],
    // chr_bank[40:33], irq_raise[41], irq_ack[42]
    output logic [M_TDATA_W-1:0]   m_tdata
);

    // configuration registers
    cfg_t    cfg_reg;

    // input register stage
    logic    in_valid_reg;
    item_t   in_item_reg;

    // result register stage
    logic    out_valid_reg;
    result_t out_result_reg;

    result_t core_result;
    logic    advance;

    // the request held in the input register moves on when the result slot is free
    // or being drained this cycle, so both stages flow every cycle under no backpressure
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || advance);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), out_result_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prg_bank_count <= PRG_COUNT_RESET;
            cfg_reg.chr_is_ram     <= 1'b0;
            cfg_reg.quad_screen    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PRG_COUNT:   cfg_reg.prg_bank_count <= cfg_data;
                CFG_CHR_IS_RAM:  cfg_reg.chr_is_ram     <= cfg_data[0];
                CFG_QUAD_SCREEN: cfg_reg.quad_screen    <= cfg_data[0];
                CFG_UNUSED:      ;
                default:         ;
            endcase
        end
    end

    // input register: capture a request whenever the slot is free or emptying
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.action       <= s_tuser;
            in_item_reg.address      <= s_tdata[15:0];
            in_item_reg.data         <= s_tdata[23:16];
            in_item_reg.rendering_on <= s_tdata[24];
        end
    end

    // mapper state and decode; state commits only when the request leaves the input register
    rbm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // result register: holds a finished result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

endmodule
